// ===== sv/alpc_pkg.sv =====
`default_nettype none

package alpc_pkg;

  localparam int SAMPLE_W = 10;
  localparam int LEVEL_W  = 8;
  localparam int SUM_W    = 16;
  localparam int CFG_IDX_W = 1;

  // Either threshold at full scale makes the pair unusable.
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hff;
  localparam int DROP_BITS = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW  = 1'b0,
    CFG_HIGH = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_FILL  = 2'd1,
    MODE_DRAIN = 2'd2
  } mode_t;

endpackage

`default_nettype wire

// ===== sv/averaged_level_pump_controller_top.sv =====
`default_nettype none

// Averaged level pump controller. Each accepted sample item is reduced to
// eight bits and added to a window sum; every SAMPLES items the window closes
// and one result item follows, carrying the truncated mean level, the two
// relay drives and the threshold error flag. A sample item is taken every
// clock cycle while in_stall is low. A result passes from the closed window
// register to the output register, and a result waiting there does not stop
// sampling until a second closed window is also waiting. The thresholds are
// written through the configuration port, which is always ready, and are
// used as they stand when a closed window moves into the result register.
module averaged_level_pump_controller_top #(
  parameter int SAMPLES = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [alpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [alpc_pkg::LEVEL_W-1:0]    cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [alpc_pkg::SAMPLE_W-1:0]   sample,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [alpc_pkg::LEVEL_W-1:0]         level,
  output logic                                 fill_on,
  output logic                                 drain_on,
  output logic                                 config_error
);

  localparam int CNT_W   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int SHIFT   = alpc_pkg::SUM_W + $clog2(SAMPLES);
  localparam int RECIP_W = alpc_pkg::SUM_W + 1;
  localparam int PROD_W  = alpc_pkg::SUM_W + RECIP_W;
  // Rounded-up reciprocal; with SHIFT this wide the quotient is exact for
  // every sum the window can hold.
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << SHIFT) + SAMPLES - 1) / SAMPLES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);

  logic [alpc_pkg::LEVEL_W-1:0] low_threshold;
  logic [alpc_pkg::LEVEL_W-1:0] high_threshold;

  logic [CNT_W-1:0]             window_count;
  logic [alpc_pkg::SUM_W-1:0]   window_sum;
  logic [alpc_pkg::SUM_W-1:0]   sum_next;
  logic [alpc_pkg::LEVEL_W-1:0] reduced;
  logic                         window_last;
  logic                         in_take;

  logic                         closed_valid;
  logic [alpc_pkg::SUM_W-1:0]   closed_sum;
  logic                         closed_move;

  logic [PROD_W-1:0]            prod;
  logic [alpc_pkg::LEVEL_W-1:0] mean;
  logic [alpc_pkg::LEVEL_W:0]   mid_sum;
  logic [alpc_pkg::LEVEL_W-1:0] mid;
  logic                         err;

  alpc_pkg::mode_t mode;
  alpc_pkg::mode_t mode_next;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold  <= '0;
      high_threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (alpc_pkg::cfg_reg_t'(cfg_index))
        alpc_pkg::CFG_LOW:  low_threshold  <= cfg_data;
        alpc_pkg::CFG_HIGH: high_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Window accumulator.
  assign closed_move = !out_valid || !out_stall;
  assign in_stall    = closed_valid && !closed_move;
  assign in_take     = in_valid && !in_stall;
  assign reduced     = sample[alpc_pkg::SAMPLE_W-1:alpc_pkg::DROP_BITS];
  assign sum_next    = window_sum + alpc_pkg::SUM_W'(reduced);
  assign window_last = (window_count == CNT_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
      window_sum   <= '0;
    end else if (in_take) begin
      if (window_last) begin
        window_count <= '0;
        window_sum   <= '0;
      end else begin
        window_count <= window_count + 1'b1;
        window_sum   <= sum_next;
      end
    end
  end

  // Closed window register.
  always_ff @(posedge clk) begin
    if (rst) begin
      closed_valid <= 1'b0;
    end else if (in_take && window_last) begin
      closed_valid <= 1'b1;
    end else if (closed_move) begin
      closed_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && window_last) begin
      closed_sum <= sum_next;
    end
  end

  // Mean, midpoint and threshold check.
  assign prod    = PROD_W'(closed_sum) * PROD_W'(RECIP);
  assign mean    = prod[SHIFT +: alpc_pkg::LEVEL_W];
  assign mid_sum = {1'b0, low_threshold} + {1'b0, high_threshold};
  assign mid     = mid_sum[alpc_pkg::LEVEL_W:1];
  assign err     = (low_threshold == '0) || (high_threshold == '0) ||
                   (low_threshold == high_threshold) ||
                   (low_threshold == alpc_pkg::LEVEL_MAX) ||
                   (high_threshold == alpc_pkg::LEVEL_MAX) ||
                   (low_threshold > high_threshold);

  // Pump mode state machine, stepped once per closed window.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= alpc_pkg::MODE_IDLE;
    end else if (closed_valid && closed_move) begin
      mode <= mode_next;
    end
  end

  always_comb begin
    mode_next = alpc_pkg::MODE_IDLE;
    if (!err) begin
      unique case (mode)
        alpc_pkg::MODE_FILL: begin
          mode_next = (mean >= mid) ? alpc_pkg::MODE_IDLE : alpc_pkg::MODE_FILL;
        end
        alpc_pkg::MODE_DRAIN: begin
          mode_next = (mean <= mid) ? alpc_pkg::MODE_IDLE : alpc_pkg::MODE_DRAIN;
        end
        default: begin
          if (mean < low_threshold) begin
            mode_next = alpc_pkg::MODE_FILL;
          end else if (mean > high_threshold) begin
            mode_next = alpc_pkg::MODE_DRAIN;
          end else begin
            mode_next = alpc_pkg::MODE_IDLE;
          end
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (closed_move) begin
      out_valid <= closed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (closed_valid && closed_move) begin
      level        <= mean;
      fill_on      <= (mode_next == alpc_pkg::MODE_FILL);
      drain_on     <= (mode_next == alpc_pkg::MODE_DRAIN);
      config_error <= err;
    end
  end

endmodule

`default_nettype wire
